// ===== hw/rtl/lrcd_pkg.sv =====
// Log record deframer package: phase codes, role codes, result record type
// and the byte-wise reflected CRC-32 step. No dependencies.
package lrcd_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    localparam logic [1:0] ROLE_KEY   = 2'd0;
    localparam logic [1:0] ROLE_VALUE = 2'd1;
    localparam logic [1:0] ROLE_NONE  = 2'd2;

    typedef enum logic [2:0] {
        PH_CRC  = 3'd0,
        PH_TYPE = 3'd1,
        PH_KLEN = 3'd2,
        PH_KEY  = 3'd3,
        PH_VLEN = 3'd4,
        PH_VAL  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_log;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [7:0]  payload_byte;
        logic        record_end;
        logic        record_ok;
        logic [7:0]  record_type;
        logic [31:0] key_length;
        logic [31:0] value_length;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/lrcd_if.sv =====
// Valid/ready channel interfaces for the log record deframer: raw byte
// request in, tagged result request out. No dependencies.
interface lrcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_log;

    modport source (output valid, output data_byte, output first_of_log, input ready);
    modport sink   (input valid, input data_byte, input first_of_log, output ready);
endinterface

interface lrcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_role;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic        record_ok;
    logic [7:0]  record_type;
    logic [31:0] key_length;
    logic [31:0] value_length;

    modport source (output valid, output byte_role, output payload_byte, output record_end,
                    output record_ok, output record_type, output key_length,
                    output value_length, input ready);
    modport sink   (input valid, input byte_role, input payload_byte, input record_end,
                    input record_ok, input record_type, input key_length,
                    input value_length, output ready);
endinterface

// ===== hw/rtl/lrcd_in_reg.sv =====
// Input register stage: captures one byte request and holds it until the
// parser consumes it. Depends on lrcd_pkg and lrcd_in_if.
module lrcd_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lrcd_in_if.sink            i_in,
    input  logic               i_adv,
    output logic               o_valid,
    output lrcd_pkg::t_in_item o_item
);
    logic               r_valid;
    lrcd_pkg::t_in_item r_item;

    assign i_in.ready = !r_valid || i_adv;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte    <= i_in.data_byte;
            r_item.first_of_log <= i_in.first_of_log;
        end
    end
endmodule

// ===== hw/rtl/lrcd_parser.sv =====
// Record parser: phase state, running CRC, length counters and verdict.
// One byte per step. Depends on lrcd_pkg.
module lrcd_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  lrcd_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output lrcd_pkg::t_result  o_res
);
    lrcd_pkg::t_phase       r_phase, n_phase, e_phase;
    logic [1:0]             r_idx, n_idx, e_idx;
    logic [31:0]            r_stored, n_stored, e_stored;
    logic [31:0]            r_run, n_run, e_run;
    logic [7:0]             r_kind, n_kind, e_kind;
    logic [31:0]            r_ksz, n_ksz, e_ksz;
    logic [31:0]            r_vsz, n_vsz, e_vsz;
    logic [LENGTH_BITS-1:0] r_left, n_left, e_left;
    logic                   r_stopped, n_stopped, e_stopped;

    logic [7:0]             b;
    logic [31:0]            byte_sh;
    logic [31:0]            crc_new;
    logic [31:0]            ksz_acc, vsz_acc;
    logic                   ksz_fits, vsz_fits;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   ok;
    logic                   idx_last;

    // a first-of-log byte sees the restarted state
    always_comb begin
        if (i_item.first_of_log) begin
            e_phase   = lrcd_pkg::PH_CRC;
            e_idx     = 2'd0;
            e_stored  = 32'd0;
            e_run     = lrcd_pkg::ALL_ONES;
            e_kind    = 8'd0;
            e_ksz     = 32'd0;
            e_vsz     = 32'd0;
            e_left    = '0;
            e_stopped = 1'b0;
        end else begin
            e_phase   = r_phase;
            e_idx     = r_idx;
            e_stored  = r_stored;
            e_run     = r_run;
            e_kind    = r_kind;
            e_ksz     = r_ksz;
            e_vsz     = r_vsz;
            e_left    = r_left;
            e_stopped = r_stopped;
        end
    end

    assign b        = i_item.data_byte;
    assign byte_sh  = {24'd0, b} << {e_idx, 3'b000};
    assign crc_new  = (e_phase != lrcd_pkg::PH_CRC) ? lrcd_pkg::crc_byte(e_run, b) : e_run;
    assign ksz_acc  = e_ksz | byte_sh;
    assign vsz_acc  = e_vsz | byte_sh;
    assign ksz_fits = (ksz_acc >> LENGTH_BITS) == 32'd0;
    assign vsz_fits = (vsz_acc >> LENGTH_BITS) == 32'd0;
    assign left_dec = e_left - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign ok       = (crc_new ^ lrcd_pkg::ALL_ONES) == e_stored;
    assign idx_last = (e_idx == 2'd3);

    // next state
    always_comb begin
        n_phase   = e_phase;
        n_idx     = e_idx;
        n_stored  = e_stored;
        n_run     = crc_new;
        n_kind    = e_kind;
        n_ksz     = e_ksz;
        n_vsz     = e_vsz;
        n_left    = e_left;
        n_stopped = e_stopped;
        if (!e_stopped) begin
            unique case (e_phase)
                lrcd_pkg::PH_TYPE: begin
                    n_kind  = b;
                    n_phase = lrcd_pkg::PH_KLEN;
                    n_idx   = 2'd0;
                end
                lrcd_pkg::PH_KLEN: begin
                    n_ksz = ksz_acc;
                    if (!idx_last) begin
                        n_idx = e_idx + 2'd1;
                    end else begin
                        n_idx = 2'd0;
                        if (!ksz_fits) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_left  = ksz_acc[LENGTH_BITS-1:0];
                            n_phase = (ksz_acc == 32'd0) ? lrcd_pkg::PH_VLEN : lrcd_pkg::PH_KEY;
                        end
                    end
                end
                lrcd_pkg::PH_KEY: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase = lrcd_pkg::PH_VLEN;
                        n_idx   = 2'd0;
                    end
                end
                lrcd_pkg::PH_VLEN: begin
                    n_vsz = vsz_acc;
                    if (!idx_last) begin
                        n_idx = e_idx + 2'd1;
                    end else begin
                        n_idx = 2'd0;
                        if (!vsz_fits) begin
                            n_stopped = 1'b1;
                        end else if (vsz_acc == 32'd0) begin
                            n_phase   = lrcd_pkg::PH_CRC;
                            n_stored  = 32'd0;
                            n_run     = lrcd_pkg::ALL_ONES;
                            n_kind    = 8'd0;
                            n_ksz     = 32'd0;
                            n_vsz     = 32'd0;
                            n_left    = '0;
                            n_stopped = !ok;
                        end else begin
                            n_left  = vsz_acc[LENGTH_BITS-1:0];
                            n_phase = lrcd_pkg::PH_VAL;
                        end
                    end
                end
                lrcd_pkg::PH_VAL: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase   = lrcd_pkg::PH_CRC;
                        n_idx     = 2'd0;
                        n_stored  = 32'd0;
                        n_run     = lrcd_pkg::ALL_ONES;
                        n_kind    = 8'd0;
                        n_ksz     = 32'd0;
                        n_vsz     = 32'd0;
                        n_left    = '0;
                        n_stopped = !ok;
                    end
                end
                default: begin
                    // stored CRC bytes; a stray phase code restarts the record
                    if (e_phase != lrcd_pkg::PH_CRC) begin
                        n_phase  = lrcd_pkg::PH_CRC;
                        n_stored = {24'd0, b};
                        n_run    = lrcd_pkg::ALL_ONES;
                        n_kind   = 8'd0;
                        n_ksz    = 32'd0;
                        n_vsz    = 32'd0;
                        n_left   = '0;
                        n_idx    = 2'd1;
                    end else begin
                        n_stored = e_stored | byte_sh;
                        if (!idx_last) begin
                            n_idx = e_idx + 2'd1;
                        end else begin
                            n_idx   = 2'd0;
                            n_phase = lrcd_pkg::PH_TYPE;
                        end
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.byte_role = lrcd_pkg::ROLE_NONE;
        if (!e_stopped) begin
            unique case (e_phase)
                lrcd_pkg::PH_KEY: begin
                    o_res_valid        = 1'b1;
                    o_res.byte_role    = lrcd_pkg::ROLE_KEY;
                    o_res.payload_byte = b;
                end
                lrcd_pkg::PH_VLEN: begin
                    if (idx_last && vsz_fits && vsz_acc == 32'd0) begin
                        o_res_valid        = 1'b1;
                        o_res.record_end   = 1'b1;
                        o_res.record_ok    = ok;
                        o_res.record_type  = e_kind;
                        o_res.key_length   = e_ksz;
                        o_res.value_length = vsz_acc;
                    end
                end
                lrcd_pkg::PH_VAL: begin
                    o_res_valid        = 1'b1;
                    o_res.byte_role    = lrcd_pkg::ROLE_VALUE;
                    o_res.payload_byte = b;
                    if (left_dec == '0) begin
                        o_res.record_end   = 1'b1;
                        o_res.record_ok    = ok;
                        o_res.record_type  = e_kind;
                        o_res.key_length   = e_ksz;
                        o_res.value_length = e_vsz;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lrcd_pkg::PH_CRC;
            r_idx     <= 2'd0;
            r_stored  <= 32'd0;
            r_run     <= lrcd_pkg::ALL_ONES;
            r_kind    <= 8'd0;
            r_ksz     <= 32'd0;
            r_vsz     <= 32'd0;
            r_left    <= '0;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_stored  <= n_stored;
            r_run     <= n_run;
            r_kind    <= n_kind;
            r_ksz     <= n_ksz;
            r_vsz     <= n_vsz;
            r_left    <= n_left;
            r_stopped <= n_stopped;
        end
    end
endmodule

// ===== hw/rtl/lrcd_out_reg.sv =====
// Result register: holds one result request until the sink takes it.
// Depends on lrcd_pkg and lrcd_out_if.
module lrcd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  lrcd_pkg::t_result i_res,
    output logic              o_can_load,
    lrcd_out_if.source        o_out
);
    logic              r_valid;
    lrcd_pkg::t_result r_res;

    assign o_can_load         = !r_valid || o_out.ready;
    assign o_out.valid        = r_valid;
    assign o_out.byte_role    = r_res.byte_role;
    assign o_out.payload_byte = r_res.payload_byte;
    assign o_out.record_end   = r_res.record_end;
    assign o_out.record_ok    = r_res.record_ok;
    assign o_out.record_type  = r_res.record_type;
    assign o_out.key_length   = r_res.key_length;
    assign o_out.value_length = r_res.value_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end
endmodule

// ===== hw/rtl/log_record_crc_deframer_top.sv =====
// Log record CRC deframer top: input register, parser, result register.
// A result is loaded into the result register as its byte leaves the input register.
// Throughput: one byte per cycle unless the sink holds off the result register; the
// byte CRC step and the length counters sit between the input and result registers.
// Reset: synchronous, active low; parser waits for a stored CRC, not stopped.
// Depends on lrcd_pkg, lrcd_if, lrcd_in_reg, lrcd_parser, lrcd_out_reg.
module log_record_crc_deframer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrcd_in_if.sink    i_in,
    lrcd_out_if.source o_out
);
    logic               s1_valid;
    lrcd_pkg::t_in_item s1_item;
    logic               can_load;
    logic               adv;
    logic               res_valid;
    lrcd_pkg::t_result  res;

    assign adv = s1_valid && can_load;

    lrcd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    lrcd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_item      (s1_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lrcd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_out       (o_out)
    );
endmodule

// ===== tb/tb_log_record_crc_deframer_top.sv =====
// Self-checking bench for log_record_crc_deframer_top: framed and broken record streams
// are driven byte by byte, and an in-bench parser with its own CRC-32 predicts each result.
// Depends on lrcd_pkg, lrcd_if and the deframer RTL.
module tb_log_record_crc_deframer_top;

    localparam int LEN_BITS     = 32;
    localparam int LIMIT_CYCLES = 400000;

    // Byte-accurate parser model plus the queue of results it still expects.
    class record_checker;
        lrcd_pkg::t_result pending_results[$];
        int unsigned       failures;
        lrcd_pkg::t_phase  phase;
        logic [1:0]        byte_idx;
        logic [31:0]       frame_crc;
        logic [31:0]       crc_acc;
        logic [31:0]       key_len;
        logic [31:0]       val_len;
        logic [31:0]       remaining;
        logic [7:0]        kind;
        bit                halted;

        function new();
            failures = 0;
            halted   = 1'b0;
            clear_record();
        endfunction

        static function logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
            logic [31:0] c;
            c = crc ^ {24'd0, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ lrcd_pkg::CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void clear_record();
            phase     = lrcd_pkg::PH_CRC;
            byte_idx  = 2'd0;
            frame_crc = '0;
            crc_acc   = lrcd_pkg::ALL_ONES;
            kind      = '0;
            key_len   = '0;
            val_len   = '0;
            remaining = '0;
        endfunction

        function void emit(logic [1:0] role, logic [7:0] b, bit last);
            lrcd_pkg::t_result r;
            r = '0;
            r.byte_role    = role;
            r.payload_byte = (role == lrcd_pkg::ROLE_NONE) ? 8'd0 : b;
            if (last) begin
                r.record_end   = 1'b1;
                r.record_ok    = ((crc_acc ^ lrcd_pkg::ALL_ONES) == frame_crc);
                r.record_type  = kind;
                r.key_length   = key_len;
                r.value_length = val_len;
                clear_record();
                if (!r.record_ok) halted = 1'b1;
            end
            pending_results = {pending_results, r};
        endfunction

        function void take_byte(logic [7:0] b, logic first);
            logic [4:0] sh;
            if (first) begin
                clear_record();
                halted = 1'b0;
            end
            if (halted) return;
            sh = {byte_idx, 3'b000};
            if (phase != lrcd_pkg::PH_CRC) crc_acc = crc32_update(crc_acc, b);
            case (phase)
                lrcd_pkg::PH_TYPE: begin
                    kind     = b;
                    phase    = lrcd_pkg::PH_KLEN;
                    byte_idx = 2'd0;
                end
                lrcd_pkg::PH_KLEN: begin
                    key_len |= {24'd0, b} << sh;
                    if (byte_idx < 2'd3) byte_idx++;
                    else begin
                        byte_idx = 2'd0;
                        if ((key_len >> LEN_BITS) != 0) halted = 1'b1;
                        else begin
                            remaining = key_len;
                            phase     = (key_len == 0) ? lrcd_pkg::PH_VLEN : lrcd_pkg::PH_KEY;
                        end
                    end
                end
                lrcd_pkg::PH_KEY: begin
                    remaining--;
                    if (remaining == 0) begin
                        phase    = lrcd_pkg::PH_VLEN;
                        byte_idx = 2'd0;
                    end
                    emit(lrcd_pkg::ROLE_KEY, b, 1'b0);
                end
                lrcd_pkg::PH_VLEN: begin
                    val_len |= {24'd0, b} << sh;
                    if (byte_idx < 2'd3) byte_idx++;
                    else begin
                        byte_idx = 2'd0;
                        if ((val_len >> LEN_BITS) != 0) halted = 1'b1;
                        else if (val_len == 0) emit(lrcd_pkg::ROLE_NONE, 8'd0, 1'b1);
                        else begin
                            remaining = val_len;
                            phase     = lrcd_pkg::PH_VAL;
                        end
                    end
                end
                lrcd_pkg::PH_VAL: begin
                    remaining--;
                    emit(lrcd_pkg::ROLE_VALUE, b, remaining == 0);
                end
                default: begin
                    if (phase != lrcd_pkg::PH_CRC) begin
                        clear_record();
                        sh = '0;
                    end
                    frame_crc |= {24'd0, b} << sh;
                    if (byte_idx < 2'd3) byte_idx++;
                    else begin
                        byte_idx = 2'd0;
                        phase    = lrcd_pkg::PH_TYPE;
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void match_result(lrcd_pkg::t_result got);
            lrcd_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: role %0d, byte %0h, end %0b",
                       got.byte_role, got.payload_byte, got.record_end);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            check_field("byte_role",    want.byte_role,    got.byte_role);
            check_field("payload_byte", want.payload_byte, got.payload_byte);
            check_field("record_end",   want.record_end,   got.record_end);
            check_field("record_ok",    want.record_ok,    got.record_ok);
            check_field("record_type",  want.record_type,  got.record_type);
            check_field("key_length",   want.key_length,   got.key_length);
            check_field("value_length", want.value_length, got.value_length);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    lrcd_in_if         in_ch ();
    lrcd_out_if        out_ch ();
    record_checker     ledger = new();
    lrcd_pkg::t_result seen;
    int                in_calm;
    int                out_calm;
    int                sent_bytes;
    bit                draining;

    log_record_crc_deframer_top #(.LENGTH_BITS(LEN_BITS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] small_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'd0;
        if (r < 85) return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.first_of_log <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        ledger.take_byte(b, first);
        sent_bytes++;
    endtask

    // One record; lengths above 48 get no payload bytes and must be cut short.
    task automatic send_record(input logic [7:0] kind, input logic [31:0] klen,
                               input logic [31:0] vlen, input bit bad, input bit fresh,
                               input int cut);
        logic [7:0]  body[$];
        logic [31:0] crc;
        int          n;
        body = {body, kind};
        for (int i = 0; i < 4; i++) body = {body, klen[8*i +: 8]};
        if (klen <= 48) begin
            for (int i = 0; i < klen; i++) body = {body, 8'($urandom_range(0, 255))};
            for (int i = 0; i < 4; i++) body = {body, vlen[8*i +: 8]};
            if (vlen <= 48)
                for (int i = 0; i < vlen; i++) body = {body, 8'($urandom_range(0, 255))};
        end
        crc = lrcd_pkg::ALL_ONES;
        foreach (body[i]) crc = record_checker::crc32_update(crc, body[i]);
        crc ^= lrcd_pkg::ALL_ONES;
        if (bad) crc ^= 32'd1 << $urandom_range(0, 31);
        n = 4 + body.size();
        if (cut >= 0 && cut < n) n = cut;
        for (int i = 0; i < n; i++)
            push_byte((i < 4) ? crc[8*i +: 8] : body[i-4], fresh && (i == 0));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.byte_role    = out_ch.byte_role;
            seen.payload_byte = out_ch.payload_byte;
            seen.record_end   = out_ch.record_end;
            seen.record_ok    = out_ch.record_ok;
            seen.record_type  = out_ch.record_type;
            seen.key_length   = out_ch.key_length;
            seen.value_length = out_ch.value_length;
            ledger.match_result(seen);
        end
    end

    initial begin
        int hold;
        int gap;
        hold = 0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (draining) out_ch.ready <= 1'b1;
            else if (hold == 0) begin
                gap = pick_gap(out_calm);
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    hold = gap;
                end else out_ch.ready <= 1'b1;
            end else hold--;
            @(posedge i_clk);
        end
    end

    initial begin
        int          pick;
        bit          need_fresh;
        logic [31:0] kl;
        logic [31:0] vl;
        logic [31:0] big;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'd0;
        in_ch.first_of_log <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty record (verdict without payload), then a one-byte key and value with bad CRC
        send_record(8'hFF, 32'd0, 32'd0, 1'b0, 1'b1, -1);
        send_record(8'h00, 32'd1, 32'd1, 1'b1, 1'b0, -1);

        need_fresh = 1'b1;
        while (sent_bytes < 440) begin
            pick = $urandom_range(0, 99);
            kl   = small_len();
            vl   = small_len();
            if (pick < 72) begin
                send_record(8'($urandom_range(0, 255)), kl, vl, 1'b0,
                            need_fresh || ($urandom_range(0, 4) == 0), -1);
                need_fresh = 1'b0;
            end else if (pick < 82) begin
                send_record(8'($urandom_range(0, 255)), kl, vl, 1'b1, need_fresh, -1);
                need_fresh = ($urandom_range(0, 3) != 0);
            end else if (pick < 89) begin
                // truncated tail
                send_record(8'($urandom_range(0, 255)), kl, vl, 1'b0, need_fresh,
                            $urandom_range(1, 12 + kl + vl));
                need_fresh = 1'b1;
            end else if (pick < 94) begin
                big = $urandom;
                if (big <= 48) big = 32'hFFFF_FFFF;
                if ($urandom_range(0, 1))
                    send_record(8'($urandom_range(0, 255)), big, vl, 1'b0, need_fresh,
                                13 + $urandom_range(0, 6));
                else
                    send_record(8'($urandom_range(0, 255)), kl, big, 1'b0, need_fresh,
                                13 + kl + $urandom_range(0, 6));
                need_fresh = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                need_fresh = 1'b1;
            end
        end
        in_ch.valid <= 1'b0;

        while (ledger.pending_results.size() != 0) @(posedge i_clk);
        draining = 1'b1;
        repeat (20) @(posedge i_clk);
        if (ledger.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lrcd_pkg.sv
hw/rtl/lrcd_if.sv
hw/rtl/lrcd_in_reg.sv
hw/rtl/lrcd_parser.sv
hw/rtl/lrcd_out_reg.sv
hw/rtl/log_record_crc_deframer_top.sv
tb/tb_log_record_crc_deframer_top.sv
